@@ design/hts_pkg.sv @@
`timescale 1ns / 1ps

package hts_pkg;

  localparam int unsigned MAX_TRIALS = 64;
  localparam int unsigned REM_W      = $clog2(MAX_TRIALS + 1);
  localparam int unsigned PROB_W     = 33;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned TRIAL_W    = 7;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED_TAUS_ONE   = 3'd0,
    CFG_SEED_TAUS_TWO   = 3'd1,
    CFG_SEED_TAUS_THREE = 3'd2,
    CFG_SEED_LCG        = 3'd3,
    CFG_TRIAL_COUNT     = 3'd4
  } cfg_idx_e;

  localparam logic [WORD_W-1:0]  RST_SEED_TAUS_ONE   = 32'd12345;
  localparam logic [WORD_W-1:0]  RST_SEED_TAUS_TWO   = 32'd67890;
  localparam logic [WORD_W-1:0]  RST_SEED_TAUS_THREE = 32'd13579;
  localparam logic [WORD_W-1:0]  RST_SEED_LCG        = 32'd24680;
  localparam logic [TRIAL_W-1:0] RST_TRIAL_COUNT     = 7'd1;

  localparam logic [WORD_W-1:0] TAUS_ONE_MASK   = 32'hFFFF_FFFE;
  localparam logic [WORD_W-1:0] TAUS_TWO_MASK   = 32'hFFFF_FFF8;
  localparam logic [WORD_W-1:0] TAUS_THREE_MASK = 32'hFFFF_FFF0;
  localparam logic [WORD_W-1:0] LCG_MUL         = 32'd1664525;
  localparam logic [WORD_W-1:0] LCG_INC         = 32'd1013904223;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } hts_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic out_free;
  } hts_stat_t;

  function automatic logic [WORD_W-1:0] taus_one_next(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] mix;
    mix = ((v << 13) ^ v) >> 19;
    return ((v & TAUS_ONE_MASK) << 12) ^ mix;
  endfunction

  function automatic logic [WORD_W-1:0] taus_two_next(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] mix;
    mix = ((v << 2) ^ v) >> 25;
    return ((v & TAUS_TWO_MASK) << 4) ^ mix;
  endfunction

  function automatic logic [WORD_W-1:0] taus_three_next(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] mix;
    mix = ((v << 3) ^ v) >> 11;
    return ((v & TAUS_THREE_MASK) << 17) ^ mix;
  endfunction

endpackage

@@ design/hts_if.sv @@
`timescale 1ns / 1ps

interface hts_in_if;
  import hts_pkg::*;
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] prob_on;
  modport source (output valid, output prob_on, input ready);
  modport sink (input valid, input prob_on, output ready);
endinterface

interface hts_out_if;
  import hts_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] success_count;
  logic [WORD_W-1:0]  last_draw;
  modport source (output valid, output success_count, output last_draw, input ready);
  modport sink (input valid, input success_count, input last_draw, output ready);
endinterface

interface hts_cfg_if;
  import hts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/hts_ctrl.sv @@
`timescale 1ns / 1ps

module hts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hts_pkg::hts_stat_t stat_i,
  output hts_pkg::hts_cmd_t  cmd_o
);
  import hts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        // The compare of the final draw completes on the edge that leaves this state.
        if (!stat_i.rem_zero) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/hts_datapath.sv @@
`timescale 1ns / 1ps

module hts_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hts_pkg::hts_cmd_t             cmd_i,
  output hts_pkg::hts_stat_t            stat_o,
  input  logic [hts_pkg::PROB_W-1:0]    prob_on_i,
  input  logic                          cfg_we_i,
  input  logic [hts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [hts_pkg::WORD_W-1:0]    cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [hts_pkg::COUNT_W-1:0]   success_count_o,
  output logic [hts_pkg::WORD_W-1:0]    last_draw_o
);
  import hts_pkg::*;

  logic [WORD_W-1:0]  seed_one_q, seed_two_q, seed_three_q, seed_lcg_q;
  logic [WORD_W-1:0]  seed_one_d, seed_two_d, seed_three_d, seed_lcg_d;
  logic [TRIAL_W-1:0] trial_count_q, trial_count_d;
  logic               reload;

  logic [WORD_W-1:0]  taus_one_q, taus_two_q, taus_three_q, lcg_q;
  logic [WORD_W-1:0]  lcg_next;
  logic [WORD_W-1:0]  draw_word;

  logic [PROB_W-1:0]  prob_q;
  logic [REM_W-1:0]   rem_q;
  logic [REM_W-1:0]   rem_load;
  logic [31:0]        trial_ext;
  logic               pend_q;
  logic               hit;
  logic [COUNT_W-1:0] count_q;
  logic [WORD_W-1:0]  draw_q;

  logic               out_valid_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [WORD_W-1:0]  out_draw_q;

  // Register file writes; a write to any seed reloads the whole generator.
  always_comb begin
    seed_one_d    = seed_one_q;
    seed_two_d    = seed_two_q;
    seed_three_d  = seed_three_q;
    seed_lcg_d    = seed_lcg_q;
    trial_count_d = trial_count_q;
    reload        = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SEED_TAUS_ONE: begin
          seed_one_d = cfg_data_i;
          reload     = 1'b1;
        end
        CFG_SEED_TAUS_TWO: begin
          seed_two_d = cfg_data_i;
          reload     = 1'b1;
        end
        CFG_SEED_TAUS_THREE: begin
          seed_three_d = cfg_data_i;
          reload       = 1'b1;
        end
        CFG_SEED_LCG: begin
          seed_lcg_d = cfg_data_i;
          reload     = 1'b1;
        end
        CFG_TRIAL_COUNT: begin
          trial_count_d = cfg_data_i[TRIAL_W-1:0];
        end
        default: begin
          reload = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_one_q    <= RST_SEED_TAUS_ONE;
      seed_two_q    <= RST_SEED_TAUS_TWO;
      seed_three_q  <= RST_SEED_TAUS_THREE;
      seed_lcg_q    <= RST_SEED_LCG;
      trial_count_q <= RST_TRIAL_COUNT;
    end else begin
      seed_one_q    <= seed_one_d;
      seed_two_q    <= seed_two_d;
      seed_three_q  <= seed_three_d;
      seed_lcg_q    <= seed_lcg_d;
      trial_count_q <= trial_count_d;
    end
  end

  assign lcg_next = lcg_q * LCG_MUL + LCG_INC;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taus_one_q   <= RST_SEED_TAUS_ONE;
      taus_two_q   <= RST_SEED_TAUS_TWO;
      taus_three_q <= RST_SEED_TAUS_THREE;
      lcg_q        <= RST_SEED_LCG;
    end else if (reload) begin
      taus_one_q   <= seed_one_d;
      taus_two_q   <= seed_two_d;
      taus_three_q <= seed_three_d;
      lcg_q        <= seed_lcg_d;
    end else if (cmd_i.step) begin
      taus_one_q   <= taus_one_next(taus_one_q);
      taus_two_q   <= taus_two_next(taus_two_q);
      taus_three_q <= taus_three_next(taus_three_q);
      lcg_q        <= lcg_next;
    end
  end

  // The uniform word of a step is formed from the state it leaves behind, so the
  // compare runs in the cycle after the step.
  assign draw_word = taus_one_q ^ taus_two_q ^ taus_three_q ^ lcg_q;
  assign hit       = pend_q && (prob_q > {1'b0, draw_word});

  assign trial_ext = 32'(trial_count_q);
  assign rem_load  = (trial_ext > MAX_TRIALS) ? REM_W'(MAX_TRIALS) : REM_W'(trial_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.step;
      if (cmd_i.load) begin
        rem_q <= rem_load;
      end else if (cmd_i.step) begin
        rem_q <= rem_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prob_q  <= prob_on_i;
      count_q <= '0;
      draw_q  <= '0;
    end else begin
      if (hit && (count_q != COUNT_MAX)) begin
        count_q <= count_q + 1'b1;
      end
      if (pend_q) begin
        draw_q <= draw_word;
      end
    end
  end

  // Output register; it frees the sample loop from the consumer's stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_count_q <= count_q;
      out_draw_q  <= draw_q;
    end
  end

  assign stat_o.rem_zero = (rem_q == '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign success_count_o = out_count_q;
  assign last_draw_o     = out_draw_q;

`ifndef SYNTHESIS
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (count_q == '0) && (draw_q == '0))
    else $error("count or draw not cleared after load");

  a_step_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !reload) |=> rem_q == REM_W'($past(rem_q) - 1'b1))
    else $error("remaining trial count did not decrement on step");

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

  a_seed_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reload |=> (taus_one_q == seed_one_q) && (lcg_q == seed_lcg_q))
    else $error("generator not reloaded from seeds");
`endif

endmodule

@@ design/hybrid_taus_binomial_sampler.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Payload                           Transfer
// prob_i    in   prob_on[32:0]                     valid && ready
// result_o  out  success_count[6:0], last_draw     valid && ready
// cfg_i     in   index[2:0], data[31:0]            valid && ready (ready tied high)
//
// An item is taken only while the controller is idle, so the next input transfer
// waits until the item before it has published its result; each item runs N steps,
// N being trial_count capped at 64, one per cycle through the single LCG multiplier.
// Reset loads the seed registers and the generator with their reset seeds.
// A held result stalls only the final publish cycle of the next item.
module hybrid_taus_binomial_sampler (
  input logic     clk_i,
  input logic     rst_ni,
  hts_in_if.sink  prob_i,
  hts_out_if.source result_o,
  hts_cfg_if.sink cfg_i
);
  import hts_pkg::*;

  hts_cmd_t  cmd;
  hts_stat_t stat;
  logic      in_ready;

  assign prob_i.ready = in_ready;
  assign cfg_i.ready  = 1'b1;

  hts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (prob_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hts_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .prob_on_i       (prob_i.prob_on),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .out_ready_i     (result_o.ready),
    .out_valid_o     (result_o.valid),
    .success_count_o (result_o.success_count),
    .last_draw_o     (result_o.last_draw)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import hts_pkg::*;

  typedef struct packed {
    logic [COUNT_W-1:0] success_count;
    logic [WORD_W-1:0]  last_draw;
  } draw_result_t;

  // Tracks the seed and trial registers and the generator, and keeps the
  // expected outcomes in input order.
  class sampler_scoreboard;
    logic [WORD_W-1:0]  seed_one, seed_two, seed_three, seed_lcg;
    logic [TRIAL_W-1:0] trial_reg;
    logic [WORD_W-1:0]  gen_one, gen_two, gen_three, gen_lcg;
    draw_result_t       expected_q[$];
    int                 mismatches;

    function new();
      seed_one   = RST_SEED_TAUS_ONE;
      seed_two   = RST_SEED_TAUS_TWO;
      seed_three = RST_SEED_TAUS_THREE;
      seed_lcg   = RST_SEED_LCG;
      trial_reg  = RST_TRIAL_COUNT;
      mismatches = 0;
      reload();
    endfunction

    function void reload();
      gen_one   = seed_one;
      gen_two   = seed_two;
      gen_three = seed_three;
      gen_lcg   = seed_lcg;
    endfunction

    // Any seed write reloads all four generator components.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        CFG_SEED_TAUS_ONE: begin
          seed_one = data;
          reload();
        end
        CFG_SEED_TAUS_TWO: begin
          seed_two = data;
          reload();
        end
        CFG_SEED_TAUS_THREE: begin
          seed_three = data;
          reload();
        end
        CFG_SEED_LCG: begin
          seed_lcg = data;
          reload();
        end
        CFG_TRIAL_COUNT: trial_reg = data[TRIAL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [WORD_W-1:0] advance();
      gen_one   = ((gen_one & TAUS_ONE_MASK) << 12) ^ (((gen_one << 13) ^ gen_one) >> 19);
      gen_two   = ((gen_two & TAUS_TWO_MASK) << 4) ^ (((gen_two << 2) ^ gen_two) >> 25);
      gen_three = ((gen_three & TAUS_THREE_MASK) << 17)
                  ^ (((gen_three << 3) ^ gen_three) >> 11);
      gen_lcg   = gen_lcg * LCG_MUL + LCG_INC;
      return gen_one ^ gen_two ^ gen_three ^ gen_lcg;
    endfunction

    function void note_prob(logic [PROB_W-1:0] prob);
      int unsigned        n;
      logic [COUNT_W-1:0] hits;
      logic [WORD_W-1:0]  word;
      n    = (trial_reg > MAX_TRIALS) ? MAX_TRIALS : trial_reg;
      hits = '0;
      word = '0;
      for (int i = 0; i < n; i++) begin
        word = advance();
        if (prob > {1'b0, word} && hits != COUNT_MAX) hits++;
      end
      expected_q.push_back('{success_count: hits, last_draw: word});
    endfunction

    function void check_result(logic [COUNT_W-1:0] cnt, logic [WORD_W-1:0] draw);
      draw_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: success_count %0d, last_draw %h", cnt, draw);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (cnt !== want.success_count) begin
        $error("success_count: expected %0d, actual %0d", want.success_count, cnt);
        mismatches++;
      end
      if (draw !== want.last_draw) begin
        $error("last_draw: expected %h, actual %h", want.last_draw, draw);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   src_idle_pct;
  int   snk_stall_pct;

  hts_in_if  prob_if ();
  hts_out_if res_if ();
  hts_cfg_if cfg_if ();

  sampler_scoreboard sb = new();

  hybrid_taus_binomial_sampler dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .prob_i   (prob_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("hybrid_taus_binomial_sampler verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && prob_if.valid && prob_if.ready) sb.note_prob(prob_if.prob_on);
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check_result(res_if.success_count, res_if.last_draw);
    end
    if (rst_ni && cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
  end

  task automatic send_prob(logic [PROB_W-1:0] prob);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      prob_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    prob_if.valid   <= 1'b1;
    prob_if.prob_on <= prob;
    do @(posedge clk_i); while (!prob_if.ready);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers only change once every outstanding result has been transferred.
  task automatic drain();
    prob_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    cfg_idx_e             seed_regs[4];
    int                   idle_tab[4];
    int                   stall_tab[4];
    logic [CFG_IDX_W-1:0] bad_idx;
    logic [TRIAL_W-1:0]   trials;
    logic [PROB_W-1:0]    prob;
    logic [WORD_W-1:0]    seed;
    int unsigned          sel;

    seed_regs = '{CFG_SEED_TAUS_ONE, CFG_SEED_TAUS_TWO, CFG_SEED_TAUS_THREE, CFG_SEED_LCG};
    idle_tab  = '{0, 56, 0, 9};
    stall_tab = '{0, 0, 56, 9};

    rst_ni          = 1'b0;
    prob_if.valid   = 1'b0;
    prob_if.prob_on = '0;
    res_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset seeds, single trial: the binary sampler at the probability edges.
    send_prob('0);
    send_prob(33'h0_FFFF_FFFF);
    send_prob(33'h1_0000_0000);
    send_prob('1);
    drain();

    cfg_write(CFG_TRIAL_COUNT, 32'd64);
    send_prob(33'h1_0000_0000);
    send_prob(33'h0_8000_0000);
    send_prob(33'h0_0000_0001);
    drain();

    // No trials: zero result and the generator must not move.
    cfg_write(CFG_TRIAL_COUNT, 32'd0);
    send_prob('1);
    send_prob('0);
    drain();

    // Counts above the maximum saturate; upper data bits are not part of the register.
    cfg_write(CFG_TRIAL_COUNT, 32'hFFFF_FFC1);
    send_prob(33'h0_8000_0000);
    drain();
    cfg_write(CFG_TRIAL_COUNT, 32'h0000_007F);
    send_prob(33'h0_4000_0000);
    drain();

    // Degenerate seeds are still used as given.
    cfg_write(CFG_SEED_TAUS_ONE, 32'd0);
    cfg_write(CFG_SEED_TAUS_TWO, 32'd1);
    cfg_write(CFG_SEED_TAUS_THREE, 32'd128);
    cfg_write(CFG_SEED_LCG, 32'd0);
    cfg_write(CFG_TRIAL_COUNT, 32'd3);
    send_prob(33'h0_8000_0000);
    send_prob(33'h1_0000_0000);
    drain();

    for (int k = 0; k < 4; k++) cfg_write(seed_regs[k], 32'hFFFF_FFFF);
    // Writes to unused indexes must neither change a register nor reload.
    for (int k = 1; k <= 3; k++) begin
      bad_idx = CFG_IDX_W'(CFG_TRIAL_COUNT) + CFG_IDX_W'(k);
      cfg_write(bad_idx, $urandom());
    end
    send_prob(33'h0_8000_0000);
    send_prob(33'h0_FFFF_FFFF);

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      src_idle_pct  = idle_tab[ph % 4];
      snk_stall_pct = stall_tab[ph % 4];
      if ($urandom_range(0, 2) != 0) begin
        for (int k = 0; k < 4; k++) begin
          seed = ($urandom_range(0, 7) == 0) ? WORD_W'($urandom_range(0, 128)) : $urandom();
          cfg_write(seed_regs[k], seed);
        end
      end
      // Mostly short items; long and saturating counts now and then.
      sel = $urandom_range(0, 9);
      if (sel < 6) trials = TRIAL_W'($urandom_range(1, 8));
      else if (sel == 6) trials = '0;
      else if (sel < 9) trials = TRIAL_W'($urandom_range(9, 64));
      else trials = TRIAL_W'($urandom_range(65, 127));
      cfg_write(CFG_TRIAL_COUNT, ($urandom() & 32'hFFFF_FF80) | WORD_W'(trials));
      if ($urandom_range(0, 3) == 0) begin
        bad_idx = CFG_IDX_W'(CFG_TRIAL_COUNT) + CFG_IDX_W'($urandom_range(1, 3));
        cfg_write(bad_idx, $urandom());
      end
      repeat (75) begin
        case ($urandom_range(0, 9))
          0: prob = '0;
          1: prob = 33'h1_0000_0000;
          2: prob = {1'b1, 32'($urandom())};
          3: prob = PROB_W'($urandom_range(0, 255));
          4: prob = {1'b0, 32'hFFFF_FF00 | 32'($urandom_range(0, 255))};
          default: prob = {1'b0, 32'($urandom())};
        endcase
        send_prob(prob);
      end
    end

    drain();
    repeat (MAX_TRIALS + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("hybrid_taus_binomial_sampler verification clean");
    end else begin
      $display("hybrid_taus_binomial_sampler verification failed");
    end
    $finish;
  end

endmodule

@@ hybrid_taus_binomial_sampler.f @@
design/hts_pkg.sv
design/hts_if.sv
design/hts_ctrl.sv
design/hts_datapath.sv
design/hybrid_taus_binomial_sampler.sv
dv/tb.sv
